>>> sv/gtrg_pkg.sv
// gtrg_pkg: shared types, constants and the 5x7 font for the glyph text rectangle generator
// no dependencies; imported by gtrg_front, gtrg_back and glyph_text_rect_generator

package gtrg_pkg;

	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int ADVANCE_CELLS = 6;
	localparam int GLYPH_COUNT = 42;

	// glyph slots of the font table
	localparam logic [5:0] GLYPH_DIGIT0 = 6'd26;
	localparam logic [5:0] GLYPH_COLON = 6'd36;
	localparam logic [5:0] GLYPH_PERIOD = 6'd37;
	localparam logic [5:0] GLYPH_MINUS = 6'd38;
	localparam logic [5:0] GLYPH_SLASH = 6'd39;
	localparam logic [5:0] GLYPH_SPACE = 6'd40;
	localparam logic [5:0] GLYPH_DEFAULT = 6'd41;

	// internal widths
	localparam int CUR_W = 14;   // cursor column
	localparam int ROW_W = 13;   // string origin row
	localparam int SCL_W = 7;    // latched scale, covers the largest scale limit
	localparam int PX_W = 15;    // cell corner coordinates and clamped screen size
	localparam int CFG_W = 13;   // screen size registers

	localparam int JOB_DEPTH = 2;
	localparam int RECT_DEPTH = 4;

	typedef enum logic {
		REG_SCREEN_W,
		REG_SCREEN_H
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} scan_state_t;

	// one character handed from the front to the back
	typedef struct packed {
		logic [5:0]       glyph;
		logic [CUR_W-1:0] cursor;
		logic [ROW_W-1:0] row;
		logic [SCL_W-1:0] scale;
		logic [31:0]      color;
	} job_t;

	// one fill rectangle word
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [4:0]  w;
		logic [4:0]  h;
		logic [31:0] color;
		logic        last;
	} rect_t;

	localparam logic [4:0] FONT_ROWS [0:GLYPH_COUNT-1][0:GLYPH_ROWS-1] = '{
		'{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // A
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}, // B
		'{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F}, // C
		'{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}, // D
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}, // E
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}, // F
		'{5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F}, // G
		'{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // H
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}, // I
		'{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C}, // J
		'{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}, // K
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}, // L
		'{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}, // M
		'{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}, // N
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // O
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}, // P
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}, // Q
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}, // R
		'{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}, // S
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // T
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // U
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04}, // V
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}, // W
		'{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11}, // X
		'{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // Y
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}, // Z
		'{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}, // 0
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}, // 1
		'{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}, // 2
		'{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}, // 3
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}, // 4
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}, // 5
		'{5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}, // 6
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}, // 7
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}, // 8
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E}, // 9
		'{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}, // colon
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}, // period
		'{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}, // minus
		'{5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}, // slash
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, // space
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04}  // question mark
	};

	// character byte to font slot, lower case folded to upper
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		logic [5:0] idx;
		c = code;
		if (c >= 8'h61 && c <= 8'h7A) begin
			c = c - 8'h20;
		end
		if (c >= 8'h41 && c <= 8'h5A) begin
			idx = 6'(c - 8'h41);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			idx = GLYPH_DIGIT0 + 6'(c - 8'h30);
		end else if (c == 8'h3A) begin
			idx = GLYPH_COLON;
		end else if (c == 8'h2E) begin
			idx = GLYPH_PERIOD;
		end else if (c == 8'h2D) begin
			idx = GLYPH_MINUS;
		end else if (c == 8'h2F) begin
			idx = GLYPH_SLASH;
		end else if (c == 8'h20) begin
			idx = GLYPH_SPACE;
		end else begin
			idx = GLYPH_DEFAULT;
		end
		return idx;
	endfunction

	function automatic logic [4:0] font_row(input logic [5:0] idx, input logic [2:0] row);
		logic [4:0] bits;
		if (idx < 6'(GLYPH_COUNT) && row < 3'(GLYPH_ROWS)) begin
			bits = FONT_ROWS[idx][row];
		end else begin
			bits = '0;
		end
		return bits;
	endfunction

endpackage

>>> sv/gtrg_fifo.sv
// gtrg_fifo: small first-in first-out queue of packed words
// no package dependencies; used for the job queue and the rectangle queue

module gtrg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/gtrg_front.sv
// gtrg_front: takes characters, keeps the string state and hands drawable ones to the back
// depends on gtrg_pkg

module gtrg_front #(
	parameter int MAX_SCALE = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [7:0]                   char_code,
	input  logic                         first_char,
	input  logic [12:0]                  start_x,
	input  logic [12:0]                  start_y,
	input  logic [31:0]                  ink_color,
	input  logic [4:0]                   scale_factor,
	input  logic [gtrg_pkg::PX_W-1:0]    wdt,
	output logic                         job_push,
	output gtrg_pkg::job_t               job,
	input  logic                         job_full
);

	import gtrg_pkg::*;

	logic [CUR_W-1:0] cursor_q;
	logic [ROW_W-1:0] origin_q;
	logic [31:0]      color_q;
	logic [SCL_W-1:0] scale_q;
	logic             stopped_q;

	logic             accept;
	logic [SCL_W-1:0] sat_scale;
	logic [CUR_W-1:0] cur_eff;
	logic [ROW_W-1:0] row_eff;
	logic [31:0]      color_eff;
	logic [SCL_W-1:0] scale_eff;
	logic             stopped_eff;
	logic [SCL_W+2:0] step6;
	logic [CUR_W:0]   cur_sum;
	logic [CUR_W-1:0] cur_next;

	assign full = job_full;
	assign accept = push && !job_full;

	always_comb begin
		if ({2'b00, scale_factor} > SCL_W'(MAX_SCALE)) begin
			sat_scale = SCL_W'(MAX_SCALE);
		end else begin
			sat_scale = {2'b00, scale_factor};
		end
	end

	// first character of a string takes the new origin, color and scale
	assign cur_eff = first_char ? {1'b0, start_x} : cursor_q;
	assign row_eff = first_char ? start_y : origin_q;
	assign color_eff = first_char ? ink_color : color_q;
	assign scale_eff = first_char ? sat_scale : scale_q;
	assign stopped_eff = first_char ? (sat_scale == '0) : stopped_q;

	// six cells per character: 4s + 2s
	assign step6 = {1'b0, scale_eff, 2'b00} + {2'b00, scale_eff, 1'b0};
	assign cur_sum = {1'b0, cur_eff} + (CUR_W + 1)'(step6);
	assign cur_next = cur_sum[CUR_W-1:0];

	assign job_push = accept && !stopped_eff;
	assign job.glyph = glyph_index(char_code);
	assign job.cursor = cur_eff;
	assign job.row = row_eff;
	assign job.scale = scale_eff;
	assign job.color = color_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			origin_q <= '0;
			color_q <= '0;
			scale_q <= '0;
			stopped_q <= 1'b1;
		end else if (accept) begin
			cursor_q <= cur_eff;
			origin_q <= row_eff;
			color_q <= color_eff;
			scale_q <= scale_eff;
			stopped_q <= stopped_eff;
			if (!stopped_eff) begin
				cursor_q <= cur_next;
				stopped_q <= ({1'b0, cur_next} >= wdt);
			end
		end
	end

endmodule

>>> sv/gtrg_back.sv
// gtrg_back: scans the 35 glyph cells of one character and emits clipped rectangles
// depends on gtrg_pkg

module gtrg_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [gtrg_pkg::PX_W-1:0] wdt,
	input  logic [gtrg_pkg::PX_W-1:0] hgt,
	input  gtrg_pkg::job_t            job,
	input  logic                      job_empty,
	output logic                      job_pop,
	output logic                      rect_push,
	output gtrg_pkg::rect_t           rect_data,
	input  logic                      rect_full
);

	import gtrg_pkg::*;

	scan_state_t      state_q;
	scan_state_t      state_d;
	logic [5:0]       glyph_q;
	logic [CUR_W-1:0] base_q;
	logic [SCL_W-1:0] scale_q;
	logic [31:0]      color_q;
	logic [2:0]       row_q;
	logic [2:0]       col_q;
	logic [PX_W-1:0]  px_q;
	logic [PX_W-1:0]  py_q;
	logic             pend_valid_q;
	rect_t            pend_q;

	logic             load;
	logic             step;
	logic             flushed;
	logic [4:0]       row_bits;
	logic             lit;
	logic             hit;
	logic             last_cell;
	logic [PX_W-1:0]  scale_ext;
	logic [PX_W-1:0]  room_x;
	logic [PX_W-1:0]  room_y;
	logic [PX_W-1:0]  cell_w;
	logic [PX_W-1:0]  cell_h;

	assign row_bits = font_row(glyph_q, row_q);
	assign lit = row_bits[3'(GLYPH_COLS - 1) - col_q];
	assign hit = lit && (px_q < wdt) && (py_q < hgt);
	assign last_cell = (row_q == 3'(GLYPH_ROWS - 1)) && (col_q == 3'(GLYPH_COLS - 1));

	// clip the cell against the right and bottom edges
	assign scale_ext = PX_W'(scale_q);
	assign room_x = wdt - px_q;
	assign room_y = hgt - py_q;
	assign cell_w = (room_x < scale_ext) ? room_x : scale_ext;
	assign cell_h = (room_y < scale_ext) ? room_y : scale_ext;

	always_comb begin
		job_pop = 1'b0;
		rect_push = 1'b0;
		rect_data = pend_q;
		load = 1'b0;
		step = 1'b0;
		flushed = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				job_pop = !job_empty;
				load = !job_empty;
			end
			ST_SCAN: begin
				// a new hit pushes out the held one, which is then known not to be last
				rect_push = hit && pend_valid_q && !rect_full;
				rect_data.last = 1'b0;
				step = !(hit && pend_valid_q && rect_full);
			end
			ST_FLUSH: begin
				rect_push = pend_valid_q && !rect_full;
				rect_data.last = 1'b1;
				flushed = !(pend_valid_q && rect_full);
				job_pop = flushed && !job_empty;
				load = flushed && !job_empty;
			end
			default: begin
				job_pop = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!job_empty) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (step && last_cell) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flushed) begin
					state_d = job_empty ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_valid_q <= 1'b0;
			row_q <= '0;
			col_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				pend_valid_q <= 1'b0;
				row_q <= '0;
				col_q <= '0;
			end else if (step) begin
				if (hit) begin
					pend_valid_q <= 1'b1;
				end
				if (col_q == 3'(GLYPH_COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (flushed) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// cell corners walk by the scale, no multiplier
	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q <= job.glyph;
			base_q <= job.cursor;
			scale_q <= job.scale;
			color_q <= job.color;
			px_q <= PX_W'(job.cursor);
			py_q <= PX_W'(job.row);
		end else if (step) begin
			if (hit) begin
				pend_q.x <= px_q[11:0];
				pend_q.y <= py_q[11:0];
				pend_q.w <= cell_w[4:0];
				pend_q.h <= cell_h[4:0];
				pend_q.color <= color_q;
				pend_q.last <= 1'b0;
			end
			if (col_q == 3'(GLYPH_COLS - 1)) begin
				px_q <= PX_W'(base_q);
				py_q <= py_q + scale_ext;
			end else begin
				px_q <= px_q + scale_ext;
			end
		end
	end

endmodule

>>> sv/glyph_text_rect_generator.sv
// glyph_text_rect_generator: 5x7 font text renderer emitting one fill rectangle per lit cell
// an idle scanner loads a taken character, scans its 35 cells one per cycle unless a full
// result queue stalls it, then a flush state releases the held last rectangle and loads the
// next character; the single cell scanner in the back finishes one character before it takes
// the next, and stopped or suppressed characters never reach it.
// reset clears both queues, sets the screen to 640 x 480 and leaves the string stopped
// depends on gtrg_pkg, gtrg_fifo, gtrg_front, gtrg_back

module glyph_text_rect_generator #(
	parameter int MAX_DIM = 4096,
	parameter int MAX_SCALE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// character words in
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        first_char,
	input  logic [12:0] start_x,
	input  logic [12:0] start_y,
	input  logic [31:0] ink_color,
	input  logic [4:0]  scale_factor,
	// rectangle words out
	output logic        empty,
	input  logic        pop,
	output logic [11:0] rect_x,
	output logic [11:0] rect_y,
	output logic [4:0]  rect_w,
	output logic [4:0]  rect_h,
	output logic [31:0] fill_color,
	output logic        last_rect,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import gtrg_pkg::*;

	logic [CFG_W-1:0] scr_w_q;
	logic [CFG_W-1:0] scr_h_q;
	logic [PX_W-1:0]  wdt;
	logic [PX_W-1:0]  hgt;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	job_t             front_job;
	logic             job_push;
	logic             job_full;
	job_t             back_job;
	logic             job_empty;
	logic             job_pop;
	rect_t            back_rect;
	logic             rect_push;
	logic             rect_full;
	rect_t            out_rect;

	// register port: zero wait states, word address bit 2 picks the register
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_SCREEN_W: prdata = 32'(scr_w_q);
			REG_SCREEN_H: prdata = 32'(scr_h_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= CFG_W'(640);
			scr_h_q <= CFG_W'(480);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SCREEN_W: scr_w_q <= pwdata[CFG_W-1:0];
				REG_SCREEN_H: scr_h_q <= pwdata[CFG_W-1:0];
				default:      scr_w_q <= scr_w_q;
			endcase
		end
	end

	// screen sizes beyond the supported dimension clamp to it
	assign wdt = (32'(scr_w_q) > 32'(MAX_DIM)) ? PX_W'(MAX_DIM) : PX_W'(scr_w_q);
	assign hgt = (32'(scr_h_q) > 32'(MAX_DIM)) ? PX_W'(MAX_DIM) : PX_W'(scr_h_q);

	// front: latches string state, folds the code to a glyph, drops stopped characters
	gtrg_front #(
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.first_char  (first_char),
		.start_x     (start_x),
		.start_y     (start_y),
		.ink_color   (ink_color),
		.scale_factor(scale_factor),
		.wdt         (wdt),
		.job_push    (job_push),
		.job         (front_job),
		.job_full    (job_full)
	);

	// short job queue lets the front keep taking words while the back scans
	gtrg_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (front_job),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (back_job),
		.empty (job_empty)
	);

	// back: one cell per cycle unless a full queue stalls it; holds one hit to flag the last
	gtrg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wdt      (wdt),
		.hgt      (hgt),
		.job      (back_job),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.rect_push(rect_push),
		.rect_data(back_rect),
		.rect_full(rect_full)
	);

	// result queue parts the scanner from the consumer
	gtrg_fifo #(
		.WIDTH($bits(rect_t)),
		.DEPTH(RECT_DEPTH)
	) u_rect_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rect_push),
		.wdata (back_rect),
		.full  (rect_full),
		.pop   (pop),
		.rdata (out_rect),
		.empty (empty)
	);

	assign rect_x = out_rect.x;
	assign rect_y = out_rect.y;
	assign rect_w = out_rect.w;
	assign rect_h = out_rect.h;
	assign fill_color = out_rect.color;
	assign last_rect = out_rect.last;

	// the scanner never writes a full result queue
	a_rect_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rect_push |-> !rect_full)
		else $error("rectangle pushed into a full queue");

	// the front never hands a job to a full queue
	a_job_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into a full queue");

	// a clipped rectangle always keeps at least one pixel each way
	a_rect_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (rect_w != 5'd0 && rect_h != 5'd0))
		else $error("rectangle with zero size");

endmodule

>>> tb/sv/tb_glyph_text_rect_generator.sv
`timescale 1ns / 100ps
// tb_glyph_text_rect_generator: self-checking bench for the 5x7 glyph text rectangle generator
// holds its own font and cell scanner, checks every rectangle word in order; needs gtrg_pkg

module tb_glyph_text_rect_generator;
	import gtrg_pkg::*;

	localparam int DIM_CAP = 4096;     // screen size clamp of the block
	localparam int SCALE_CAP = 16;     // scale clamp of the block
	localparam int LIMIT = 400000;     // cycle budget for the whole run
	localparam int SETTLE = 150;       // three queued character scans with no output plus margin
	localparam int DRAIN_CAP = 30000;  // bound on waiting for outstanding rectangles

	// font slots, same order as the glyph rom
	localparam int SLOT_DIGIT0 = 26;
	localparam int SLOT_COLON = 36;
	localparam int SLOT_PERIOD = 37;
	localparam int SLOT_MINUS = 38;
	localparam int SLOT_SLASH = 39;
	localparam int SLOT_SPACE = 40;
	localparam int SLOT_UNKNOWN = 41;

	// seven rows of five cells per glyph, top row in the upper bits, left cell first
	localparam logic [34:0] GLYPH_BITS [0:41] = '{
		{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // A
		{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}, // B
		{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F}, // C
		{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}, // D
		{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}, // E
		{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}, // F
		{5'h0F, 5'h10, 5'h10, 5'h13, 5'h11, 5'h11, 5'h0F}, // G
		{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // H
		{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F}, // I
		{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C}, // J
		{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}, // K
		{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}, // L
		{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11}, // M
		{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11}, // N
		{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // O
		{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10}, // P
		{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D}, // Q
		{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11}, // R
		{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E}, // S
		{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // T
		{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // U
		{5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h0A, 5'h04}, // V
		{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A}, // W
		{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11}, // X
		{5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // Y
		{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}, // Z
		{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E}, // 0
		{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}, // 1
		{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F}, // 2
		{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E}, // 3
		{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02}, // 4
		{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E}, // 5
		{5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E}, // 6
		{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08}, // 7
		{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E}, // 8
		{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E}, // 9
		{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}, // colon
		{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C}, // period
		{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00}, // minus
		{5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10}, // slash
		{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, // space
		{5'h1F, 5'h01, 5'h02, 5'h04, 5'h04, 5'h00, 5'h04}  // question mark
	};

	// one rectangle word as seen on the result ports
	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [4:0]  w;
		logic [4:0]  h;
		logic [31:0] color;
		logic        last;
	} fill_rect_t;

	// character byte to font slot, lower case folded, anything else shows the question mark
	function automatic int font_slot(logic [7:0] ch);
		logic [7:0] up;
		up = ch;
		if (up >= "a" && up <= "z") begin
			up = up - 8'd32;
		end
		if (up >= "A" && up <= "Z") begin
			return int'(up - "A");
		end
		if (up >= "0" && up <= "9") begin
			return SLOT_DIGIT0 + int'(up - "0");
		end
		case (up)
			":": return SLOT_COLON;
			".": return SLOT_PERIOD;
			"-": return SLOT_MINUS;
			"/": return SLOT_SLASH;
			" ": return SLOT_SPACE;
			default: return SLOT_UNKNOWN;
		endcase
	endfunction

	// string state, screen size and the queue of rectangles still owed by the block
	class rect_scoreboard;
		fill_rect_t  rects_due[$];
		int          errors;
		logic [12:0] scr_w;
		logic [12:0] scr_h;
		logic [13:0] cursor;
		logic [12:0] row;
		logic [31:0] color;
		logic [4:0]  scale;
		bit          stopped;

		function new();
			scr_w = 13'd640;
			scr_h = 13'd480;
			cursor = '0;
			row = '0;
			color = '0;
			scale = '0;
			stopped = 1'b1;
			errors = 0;
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] %s", $realtime, msg);
			end
		endfunction

		function void set_reg(reg_idx_t r, logic [12:0] v);
			if (r == REG_SCREEN_W) begin
				scr_w = v;
			end else begin
				scr_h = v;
			end
		endfunction

		function int screen_cols();
			return (int'(scr_w) > DIM_CAP) ? DIM_CAP : int'(scr_w);
		endfunction

		function int screen_rows();
			return (int'(scr_h) > DIM_CAP) ? DIM_CAP : int'(scr_h);
		endfunction

		// accepted character word: queue its rectangles, returns 0 when the word is ignored
		function bit note_char(logic [7:0] code, bit first, logic [12:0] sx, logic [12:0] sy,
				logic [31:0] ink, logic [4:0] scl);
			int wd, ht, sc, px, py, n, nxt;
			logic [34:0] cells;
			fill_rect_t r;
			wd = screen_cols();
			ht = screen_rows();
			if (first) begin
				cursor = 14'(sx);
				row = sy;
				color = ink;
				scale = (int'(scl) > SCALE_CAP) ? 5'(SCALE_CAP) : scl;
				stopped = (scale == 0);
			end
			if (stopped) begin
				return 1'b0;
			end
			sc = int'(scale);
			cells = GLYPH_BITS[font_slot(code)];
			n = 0;
			for (int rr = 0; rr < 7; rr++) begin
				for (int cc = 0; cc < 5; cc++) begin
					px = int'(cursor) + cc * sc;
					py = int'(row) + rr * sc;
					if (cells[34 - 5 * rr - cc] && px < wd && py < ht) begin
						r.x = 12'(px);
						r.y = 12'(py);
						r.w = 5'((wd - px < sc) ? wd - px : sc);
						r.h = 5'((ht - py < sc) ? ht - py : sc);
						r.color = color;
						r.last = 1'b0;
						rects_due.push_back(r);
						n++;
					end
				end
			end
			if (n > 0) begin
				rects_due[rects_due.size() - 1].last = 1'b1;
			end
			nxt = int'(cursor) + 6 * sc;
			cursor = 14'(nxt);
			if (int'(cursor) >= wd) begin
				stopped = 1'b1;
			end
			return 1'b1;
		endfunction

		function void check_rect(fill_rect_t got);
			fill_rect_t want;
			if (rects_due.size() == 0) begin
				flag($sformatf("unexpected rect x=%0d y=%0d w=%0d h=%0d color=%h last=%0d",
					got.x, got.y, got.w, got.h, got.color, got.last));
			end else begin
				want = rects_due.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
						got.h !== want.h || got.color !== want.color || got.last !== want.last) begin
					flag($sformatf({"rect mismatch: want x=%0d y=%0d w=%0d h=%0d color=%h last=%0d",
						" got x=%0d y=%0d w=%0d h=%0d color=%h last=%0d"},
						want.x, want.y, want.w, want.h, want.color, want.last,
						got.x, got.y, got.w, got.h, got.color, got.last));
				end
			end
		endfunction
	endclass

	// block ports, every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  char_code = '0;
	logic        first_char = 1'b0;
	logic [12:0] start_x = '0;
	logic [12:0] start_y = '0;
	logic [31:0] ink_color = '0;
	logic [4:0]  scale_factor = '0;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        full;
	logic        empty;
	logic [11:0] rect_x;
	logic [11:0] rect_y;
	logic [4:0]  rect_w;
	logic [4:0]  rect_h;
	logic [31:0] fill_color;
	logic        last_rect;
	logic [31:0] prdata;
	logic        pready;

	rect_scoreboard sb;
	int cycles = 0;
	int hold_request = 0;   // receiver stall length asked by the stimulus, taken by the receiver
	bit no_idle = 1'b0;     // both sides run flat out while set

	glyph_text_rect_generator #(
		.MAX_DIM(DIM_CAP),
		.MAX_SCALE(SCALE_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.first_char(first_char),
		.start_x(start_x),
		.start_y(start_y),
		.ink_color(ink_color),
		.scale_factor(scale_factor),
		.empty(empty),
		.pop(pop),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.fill_color(fill_color),
		.last_rect(last_rect),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #2 clk = ~clk;

	// run budget; a hang anywhere ends here
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// offer one character word and hold it until taken, then maybe leave a gap
	task automatic send_char(input logic [7:0] code, input bit first, input logic [12:0] sx,
			input logic [12:0] sy, input logic [31:0] ink, input logic [4:0] scl, output bit drew);
		push <= 1'b1;
		char_code <= code;
		first_char <= first;
		start_x <= sx;
		start_y <= sy;
		ink_color <= ink;
		scale_factor <= scl;
		do @(posedge clk); while (full !== 1'b0);
		drew = sb.note_char(code, first, sx, sy, ink, scl);
		if (!no_idle && $urandom_range(99) < 12) begin
			push <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
	endtask

	// stop offering, wait for every owed rectangle, then let a scan with no output finish
	task automatic wait_idle();
		int waited;
		waited = 0;
		push <= 1'b0;
		@(posedge clk);
		while (sb.rects_due.size() != 0 && waited < DRAIN_CAP) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write, setup then access, followed by a read back of the same register
	task automatic set_screen(reg_idx_t r, logic [12:0] v);
		logic [31:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= {19'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		sb.set_reg(r, v);
		if (rd[12:0] !== v) begin
			sb.flag($sformatf("register %s read back %h, wrote %h", r.name(), rd[12:0], v));
		end
	endtask

	// mostly letters and digits, some punctuation, some arbitrary bytes
	function automatic logic [7:0] pick_code();
		int k;
		k = $urandom_range(99);
		if (k < 35) begin
			return 8'("A" + $urandom_range(25));
		end else if (k < 55) begin
			return 8'("a" + $urandom_range(25));
		end else if (k < 70) begin
			return 8'("0" + $urandom_range(9));
		end else if (k < 80) begin
			case ($urandom_range(4))
				0: return ":";
				1: return ".";
				2: return "-";
				3: return "/";
				default: return " ";
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// small cells dominate so the scan stays short; zero and oversized show up now and then
	function automatic logic [4:0] pick_scale();
		int k;
		k = $urandom_range(99);
		if (k < 5) begin
			return 5'd0;
		end else if (k < 70) begin
			return 5'($urandom_range(4, 1));
		end else if (k < 85) begin
			return 5'($urandom_range(16, 5));
		end
		return 5'($urandom_range(31, 17));
	endfunction

	// random strings until the quota of character words sent is met
	task automatic run_strings(int quota);
		int counted, len, wd, ht;
		bit drew, first;
		logic [12:0] sx, sy;
		counted = 0;
		while (counted < quota) begin
			wd = sb.screen_cols();
			ht = sb.screen_rows();
			if ($urandom_range(7) == 0 || wd == 0 || ht == 0) begin
				sx = 13'($urandom);
				sy = 13'($urandom);
			end else begin
				sx = 13'($urandom_range(wd - 1, 0));
				sy = 13'($urandom_range(ht - 1, 0));
			end
			len = $urandom_range(10, 1);
			for (int i = 0; i < len; i++) begin
				// one string in ten starts without its first-character flag
				first = (i == 0) && ($urandom_range(9) != 0);
				send_char(pick_code(), first, (i == 0) ? sx : 13'($urandom),
					(i == 0) ? sy : 13'($urandom), $urandom,
					(i == 0) ? pick_scale() : 5'($urandom), drew);
				counted++;
			end
		end
	endtask

	// receiver: checks each popped word, stalls at random and on request
	initial begin
		int hold_left;
		int idle_left;
		fill_rect_t got;
		hold_left = 0;
		idle_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && empty === 1'b0) begin
				got = {rect_x, rect_y, rect_w, rect_h, fill_color, last_rect};
				sb.check_rect(got);
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (idle_left > 0) begin
				pop <= 1'b0;
				idle_left--;
			end else if (!no_idle && $urandom_range(99) < 4) begin
				pop <= 1'b0;
				idle_left = $urandom_range(5);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus: directed corners first, then random strings under several screen sizes
	initial begin
		bit drew;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 640 x 480 screen straight out of reset
		send_char("A", 1'b0, 13'd0, 13'd0, 32'h0, 5'd1, drew);          // string not started yet
		send_char("A", 1'b1, 13'd0, 13'd0, 32'hFFFF_FFFF, 5'd1, drew);
		send_char("z", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);          // lower case folds
		send_char("0", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char("9", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char(":", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char(".", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char("-", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char("/", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char(" ", 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);          // blank, cursor still moves
		send_char(8'hFF, 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);        // no glyph, question mark
		send_char(8'h00, 1'b0, 13'd0, 13'd0, 32'h0, 5'd0, drew);
		send_char("M", 1'b1, 13'd5, 13'd7, 32'h0, 5'd0, drew);          // zero scale suppresses
		send_char("B", 1'b0, 13'd0, 13'd0, 32'h0, 5'd1, drew);
		// oversized scale at the lower right corner, clipped, then the cursor runs off
		send_char("W", 1'b1, 13'd620, 13'd470, 32'hA5A5_5A5A, 5'd31, drew);
		send_char("Q", 1'b0, 13'd0, 13'd0, 32'h0, 5'd1, drew);
		// origin far beyond the screen
		send_char("8", 1'b1, 13'h1FFF, 13'h1FFF, 32'h0, 5'd16, drew);
		send_char("8", 1'b0, 13'd0, 13'd0, 32'h0, 5'd1, drew);
		// largest cells, then a second character of the same string
		send_char("8", 1'b1, 13'd0, 13'd0, 32'h5A5A_A5A5, 5'd16, drew);
		send_char("N", 1'b0, 13'd0, 13'd0, 32'h0, 5'd1, drew);
		wait_idle();

		// zero width clips everything and stops after one character
		set_screen(REG_SCREEN_W, 13'd0);
		send_char("H", 1'b1, 13'd0, 13'd0, 32'h1234_5678, 5'd2, drew);
		send_char("I", 1'b0, 13'd0, 13'd0, 32'h0, 5'd2, drew);
		wait_idle();
		// zero height: nothing drawn but the string keeps going
		set_screen(REG_SCREEN_W, 13'd640);
		set_screen(REG_SCREEN_H, 13'd0);
		send_char("W", 1'b1, 13'd0, 13'd0, 32'h8765_4321, 5'd3, drew);
		send_char("X", 1'b0, 13'd0, 13'd0, 32'h0, 5'd3, drew);
		wait_idle();

		// largest screen; the receiver holds off long enough for the block to back up
		set_screen(REG_SCREEN_W, 13'd4096);
		set_screen(REG_SCREEN_H, 13'd4096);
		hold_request = 500;
		run_strings(60);
		wait_idle();

		// registers above the clamp, no idling on either side
		set_screen(REG_SCREEN_W, 13'h1FFF);
		set_screen(REG_SCREEN_H, 13'h1FFF);
		no_idle = 1'b1;
		run_strings(50);
		wait_idle();
		no_idle = 1'b0;

		// one column wide, every string stops after its first character
		set_screen(REG_SCREEN_W, 13'd1);
		set_screen(REG_SCREEN_H, 13'd4096);
		run_strings(20);
		wait_idle();

		// empty screen
		set_screen(REG_SCREEN_W, 13'd0);
		set_screen(REG_SCREEN_H, 13'd0);
		run_strings(10);
		wait_idle();

		// arbitrary screen, then a small one where clipping is frequent
		set_screen(REG_SCREEN_W, 13'($urandom_range(4096, 1)));
		set_screen(REG_SCREEN_H, 13'($urandom_range(4096, 1)));
		run_strings(50);
		wait_idle();
		set_screen(REG_SCREEN_W, 13'($urandom_range(400, 40)));
		set_screen(REG_SCREEN_H, 13'($urandom_range(300, 20)));
		run_strings(45);
		wait_idle();

		if (sb.rects_due.size() != 0) begin
			sb.flag($sformatf("%0d rectangles never arrived", sb.rects_due.size()));
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
